// ===== sv/hsls_pkg.sv =====
// Shared types and constants for the hsync line pixel sampler.
// No dependencies; compiled first.
package hsls_pkg;

    localparam int COLOR_W   = 9;
    localparam int COORD_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 10;
    localparam int SPP_W     = 4;
    localparam int SCAN_W    = 10;
    localparam int PORCH_W   = 7;
    localparam int WIN_W     = 13;
    localparam int PHASE_W   = 3;
    localparam int LINE_W    = 9;

    localparam logic [SPP_W-1:0]  SPP_MAX  = 4'd8;
    localparam logic [SCAN_W-1:0] SPF_MAX  = 10'd512;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLES_PER_PCLK  = 2'd0,
        CFG_PIXELS_PER_SCAN   = 2'd1,
        CFG_BACK_PORCH_PIXELS = 2'd2,
        CFG_SCANS_PER_FIELD   = 2'd3
    } cfg_index_t;

    // Effective (clamped) configuration seen by the line timer.
    typedef struct packed {
        logic [SPP_W-1:0]   spp;
        logic [WIN_W-1:0]   window;
        logic [PORCH_W-1:0] back_porch;
        logic [SCAN_W-1:0]  spf;
    } eff_cfg_t;

endpackage

// ===== sv/hsls_chan_if.sv =====
// Channel interfaces: sample words in, pixel words out, config writes.
// Depends on hsls_pkg.
interface hsls_sample_if;
    import hsls_pkg::*;
    logic               valid;
    logic               ready;
    logic               sync_level;
    logic [COLOR_W-1:0] raw_color;

    modport source (output valid, output sync_level, output raw_color, input ready);
    modport sink   (input valid, input sync_level, input raw_color, output ready);
endinterface

interface hsls_pixel_if;
    import hsls_pkg::*;
    logic               valid;
    logic               ready;
    logic               pixel_valid;
    logic [COLOR_W-1:0] pixel_color;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic               field_done;

    modport source (output valid, output pixel_valid, output pixel_color, output column,
                    output row, output field_done, input ready);
    modport sink   (input valid, input pixel_valid, input pixel_color, input column,
                    input row, input field_done, output ready);
endinterface

interface hsls_cfg_if;
    import hsls_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/hsls_cfg_regs.sv =====
// Configuration register file with clamping of the effective values.
// Depends on hsls_pkg and hsls_cfg_if.
module hsls_cfg_regs (
    input  logic             clk,
    input  logic             rst_n,
    hsls_cfg_if.sink         cfg,
    output hsls_pkg::eff_cfg_t eff
);
    import hsls_pkg::*;

    logic [SPP_W-1:0]   spp_reg;
    logic [SCAN_W-1:0]  pps_reg;
    logic [PORCH_W-1:0] bpp_reg;
    logic [SCAN_W-1:0]  spf_reg;
    logic [SPP_W-1:0]   spp_eff;
    logic [WIN_W:0]     win_prod;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spp_reg <= 4'd1;
            pps_reg <= 10'd341;
            bpp_reg <= 7'd0;
            spf_reg <= 10'd262;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg_index_t'(cfg.index))
                CFG_SAMPLES_PER_PCLK:  spp_reg <= cfg.data[SPP_W-1:0];
                CFG_PIXELS_PER_SCAN:   pps_reg <= cfg.data[SCAN_W-1:0];
                CFG_BACK_PORCH_PIXELS: bpp_reg <= cfg.data[PORCH_W-1:0];
                CFG_SCANS_PER_FIELD:   spf_reg <= cfg.data[SCAN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (spp_reg == '0)
            spp_eff = 4'd1;
        else if (spp_reg > SPP_MAX)
            spp_eff = SPP_MAX;
        else
            spp_eff = spp_reg;

        win_prod = (WIN_W+1)'(pps_reg) * (WIN_W+1)'(spp_eff);

        eff.spp        = spp_eff;
        eff.window     = (win_prod == '0) ? WIN_W'(1) : win_prod[WIN_W-1:0];
        eff.back_porch = bpp_reg;
        eff.spf        = (spf_reg > SPF_MAX) ? SPF_MAX : spf_reg;
    end

endmodule

// ===== sv/hsync_line_pixel_sampler.sv =====
// Takes one sample word per cycle unless stalled. A word is taken whenever the output register
// is empty or is being drained in the same cycle, so the sustained rate is one sample per clock;
// the result word (pixel and/or field end) appears in the cycle after its sample, held in a
// single output register; all per-sample counter updates are combinational between registers.
// Depends on hsls_pkg, hsls_chan_if and hsls_cfg_regs.
module hsync_line_pixel_sampler #(
    parameter int VISIBLE_WIDTH  = 256,
    parameter int VISIBLE_HEIGHT = 240
) (
    input  logic        clk,
    input  logic        rst_n,
    hsls_sample_if.sink samples,
    hsls_pixel_if.source pixels,
    hsls_cfg_if.sink    cfg
);
    import hsls_pkg::*;

    localparam int CW = $clog2(VISIBLE_WIDTH + 1);

    eff_cfg_t eff;

    hsls_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .eff   (eff)
    );

    logic               line_active_reg, line_active_next;
    logic               sync_passed_reg, sync_passed_next;
    logic [WIN_W-1:0]   window_count_reg, window_count_next;
    logic [PORCH_W-1:0] porch_count_reg, porch_count_next;
    logic [PHASE_W-1:0] phase_count_reg, phase_count_next;
    logic [CW-1:0]      column_count_reg, column_count_next;
    logic [LINE_W-1:0]  line_count_reg, line_count_next;

    logic               out_valid_reg, out_valid_next;
    logic               pixel_valid_reg;
    logic [COLOR_W-1:0] pixel_color_reg;
    logic [COORD_W-1:0] column_reg;
    logic [COORD_W-1:0] row_reg;
    logic               field_done_reg;

    logic               accept;
    logic               pix;
    logic               done;
    logic [COORD_W-1:0] pix_col;
    logic [COORD_W-1:0] pix_row;
    logic [PHASE_W:0]   phase_inc;
    logic [PHASE_W-1:0] phase_adv;
    logic [WIN_W:0]     window_sum;
    logic [SCAN_W-1:0]  line_sum;

    assign samples.ready = !out_valid_reg || pixels.ready;
    assign accept        = samples.valid && samples.ready;

    always_comb
    begin
        line_active_next  = line_active_reg;
        sync_passed_next  = sync_passed_reg;
        window_count_next = window_count_reg;
        porch_count_next  = porch_count_reg;
        phase_count_next  = phase_count_reg;
        column_count_next = column_count_reg;
        line_count_next   = line_count_reg;
        pix        = 1'b0;
        done       = 1'b0;
        pix_col    = '0;
        pix_row    = '0;
        phase_inc  = '0;
        phase_adv  = '0;
        window_sum = '0;
        line_sum   = '0;

        if (line_active_reg || samples.sync_level)
        begin
            if (!line_active_reg)
            begin
                sync_passed_next  = 1'b0;
                window_count_next = '0;
                porch_count_next  = '0;
                phase_count_next  = '0;
                column_count_next = '0;
            end

            if (!samples.sync_level)
                sync_passed_next = 1'b1;

            phase_inc = {1'b0, phase_count_next} + 1'b1;
            phase_adv = (phase_inc >= eff.spp) ? '0 : phase_inc[PHASE_W-1:0];

            if (sync_passed_next)
            begin
                if (porch_count_next < eff.back_porch)
                begin
                    phase_count_next = phase_adv;
                    if (phase_adv == '0)
                        porch_count_next = porch_count_next + 1'b1;
                end
                else
                begin
                    if (phase_count_next == '0 && column_count_next < CW'(VISIBLE_WIDTH))
                    begin
                        if ({1'b0, line_count_reg} < SCAN_W'(VISIBLE_HEIGHT))
                        begin
                            pix     = 1'b1;
                            pix_col = COORD_W'(column_count_next);
                            pix_row = line_count_reg[COORD_W-1:0];
                        end
                        column_count_next = column_count_next + 1'b1;
                    end
                    phase_count_next = phase_adv;
                end
            end

            window_sum = {1'b0, window_count_next} + 1'b1;
            if (window_sum >= {1'b0, eff.window})
            begin
                line_active_next  = 1'b0;
                window_count_next = '0;
                line_sum = {1'b0, line_count_reg} + 1'b1;
                if (line_sum >= eff.spf)
                begin
                    line_count_next = '0;
                    done            = 1'b1;
                end
                else
                begin
                    line_count_next = line_sum[LINE_W-1:0];
                end
            end
            else
            begin
                line_active_next  = 1'b1;
                window_count_next = window_sum[WIN_W-1:0];
            end
        end

        if (accept)
            out_valid_next = pix || done;
        else if (pixels.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_active_reg  <= 1'b0;
            sync_passed_reg  <= 1'b0;
            window_count_reg <= '0;
            porch_count_reg  <= '0;
            phase_count_reg  <= '0;
            column_count_reg <= '0;
            line_count_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                line_active_reg  <= line_active_next;
                sync_passed_reg  <= sync_passed_next;
                window_count_reg <= window_count_next;
                porch_count_reg  <= porch_count_next;
                phase_count_reg  <= phase_count_next;
                column_count_reg <= column_count_next;
                line_count_reg   <= line_count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pixel_valid_reg <= pix;
            pixel_color_reg <= pix ? samples.raw_color : '0;
            column_reg      <= pix_col;
            row_reg         <= pix_row;
            field_done_reg  <= done;
        end
    end

    assign pixels.valid       = out_valid_reg;
    assign pixels.pixel_valid = pixel_valid_reg;
    assign pixels.pixel_color = pixel_color_reg;
    assign pixels.column      = column_reg;
    assign pixels.row         = row_reg;
    assign pixels.field_done  = field_done_reg;

endmodule

// ===== sv/hsls_checker.sv =====
// Port-level checks for hsync_line_pixel_sampler, attached by bind.
// Depends on hsls_pkg; binds to the top level.
module hsls_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic                   pixel_valid,
    input logic [hsls_pkg::COLOR_W-1:0] pixel_color,
    input logic [hsls_pkg::COORD_W-1:0] column,
    input logic [hsls_pkg::COORD_W-1:0] row,
    input logic                   field_done
);
    import hsls_pkg::*;

    // every word carries a pixel, a field end, or both
    a_word_has_content: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pixel_valid || field_done))
        else $error("result word with neither pixel nor field end");

    // field-end-only words carry zeroed pixel fields
    a_blank_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !pixel_valid) |-> (pixel_color == '0 && column == '0 && row == '0))
        else $error("pixel fields not zero on a non-pixel word");

    // sample side is never held off while the output register is free
    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || out_ready) |-> in_ready)
        else $error("sample channel stalled with free output register");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(pixel_valid)
            && $stable(pixel_color) && $stable(column) && $stable(row)
            && $stable(field_done)))
        else $error("stalled result word changed");

endmodule

bind hsync_line_pixel_sampler hsls_checker u_hsls_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (samples.ready),
    .out_valid   (pixels.valid),
    .out_ready   (pixels.ready),
    .pixel_valid (pixels.pixel_valid),
    .pixel_color (pixels.pixel_color),
    .column      (pixels.column),
    .row         (pixels.row),
    .field_done  (pixels.field_done)
);
